[rtl/pidl_pkg.sv]
package pidl_pkg;

    // Store size and derived widths
    localparam int CAPACITY  = 64;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int IDX_OUT_W = 6;
    localparam int STAT_W    = 2;
    localparam int REQ_W     = 2;
    localparam int CIDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WIDE_W    = (CIDX_W > IDX_OUT_W) ? CIDX_W : IDX_OUT_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    // Chain operations broadcast to every cell
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CMP_W-1:0]  pos;       // insert/delete position
        logic [CMP_W-1:0]  last_idx;  // live count minus one, for rotation wrap
        logic [DATA_W-1:0] value;     // value to insert
    } t_cell_ctrl;

endpackage

[rtl/pidl_cell.sv]
module pidl_cell (
    input  logic                       i_clk,
    input  pidl_pkg::t_cell_ctrl       i_ctrl,
    input  logic [pidl_pkg::CIDX_W-1:0] i_idx,
    input  logic [pidl_pkg::DATA_W-1:0] i_left,
    input  logic [pidl_pkg::DATA_W-1:0] i_right,
    input  logic [pidl_pkg::DATA_W-1:0] i_head,
    output logic [pidl_pkg::DATA_W-1:0] o_data
);
    import pidl_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [CMP_W-1:0]  w_idx;

    assign w_idx = CMP_W'(i_idx);

    // Next entry: hold, shift up, shift down or rotate toward the head
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INS: begin
                if (w_idx > i_ctrl.pos) begin
                    n_data = i_left;
                end else if (w_idx == i_ctrl.pos) begin
                    n_data = i_ctrl.value;
                end
            end
            OP_DEL: begin
                if (w_idx >= i_ctrl.pos) begin
                    n_data = i_right;
                end
            end
            OP_ROT: begin
                if (w_idx == i_ctrl.last_idx) begin
                    n_data = i_head;
                end else if (w_idx < i_ctrl.last_idx) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/positional_insert_delete_list.sv]
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_req_type, i_position, i_value
// out     | output    | o_out_valid / i_out_ready | o_data_out, o_index_out, o_status, o_last
//
// Insert and delete shift all cells in the same cycle as the request is taken.
// A read-out gives one result per cycle when the output is not stalled, count results in all,
// and the cell chain rotates one place per result; no new request is taken meanwhile.
// Reset (synchronous, active low) clears the count and the output valid and returns to idle.
// A stalled output holds the chain and the read-out in place.
module positional_insert_delete_list (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pidl_pkg::REQ_W-1:0]         i_req_type,
    input  logic [pidl_pkg::POS_W-1:0]         i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pidl_pkg::DATA_W-1:0] o_data_out,
    output logic [pidl_pkg::IDX_OUT_W-1:0]     o_index_out,
    output logic [pidl_pkg::STAT_W-1:0]        o_status,
    output logic                               o_last
);
    import pidl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                 r_state,     n_state;
    logic [CNT_W-1:0]     r_count,     n_count;
    logic [CIDX_W-1:0]    r_rd_idx,    n_rd_idx;
    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_data,      n_data;
    logic [IDX_OUT_W-1:0] r_index,     n_index;
    logic [STAT_W-1:0]    r_status,    n_status;
    logic                 r_last,      n_last;

    t_cell_ctrl           w_ctrl;
    logic [DATA_W-1:0]    w_cell [CAPACITY];
    logic                 w_out_free;
    logic                 w_in_xfer;
    logic [CMP_W-1:0]     w_pos;
    logic [CMP_W-1:0]     w_cnt;
    logic                 w_rd_last;

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (CIDX_W'(g)),
            .i_left  (w_cell[(g > 0) ? g - 1 : 0]),
            .i_right (w_cell[(g < CAPACITY - 1) ? g + 1 : CAPACITY - 1]),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    // Handshake
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_pos     = CMP_W'(i_position);
    assign w_cnt     = CMP_W'(r_count);
    assign w_rd_last = (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1)));

    // Request decode and read-out sequencing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        n_data      = r_data;
        n_index     = r_index;
        n_status    = r_status;
        n_last      = r_last;

        w_ctrl.op       = OP_HOLD;
        w_ctrl.pos      = w_pos;
        w_ctrl.last_idx = CMP_W'(r_count - CNT_W'(1));
        w_ctrl.value    = i_value;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_in_xfer) begin
            n_data   = '0;
            n_index  = '0;
            n_last   = 1'b1;
            n_status = STAT_OK;
            n_out_valid = 1'b1;
            case (i_req_type)
                REQ_INS: begin
                    if (w_pos > w_cnt) begin
                        n_status = STAT_BADPOS;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_ctrl.op = OP_INS;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                REQ_DEL: begin
                    if (w_pos >= w_cnt) begin
                        n_status = STAT_BADPOS;
                    end else begin
                        w_ctrl.op = OP_DEL;
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                REQ_READ: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                        n_rd_idx    = '0;
                    end
                end
                default: begin
                    n_status = STAT_BADPOS;
                end
            endcase
        end else if (r_state == S_READ && w_out_free) begin
            // head cell goes out, chain rotates one place
            w_ctrl.op   = OP_ROT;
            n_out_valid = 1'b1;
            n_data      = w_cell[0];
            n_index     = WIDE_W'(r_rd_idx) & WIDE_W'({IDX_OUT_W{1'b1}});
            n_status    = STAT_OK;
            n_last      = w_rd_last;
            n_rd_idx    = r_rd_idx + CIDX_W'(1);
            if (w_rd_last) begin
                n_state = S_IDLE;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_data   <= n_data;
        r_index  <= n_index;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data;
    assign o_index_out = r_index;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

[sim/list_result_checker.sv]
module list_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [pidl_pkg::REQ_W-1:0]          i_req_type,
    input  logic [pidl_pkg::POS_W-1:0]          i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [pidl_pkg::DATA_W-1:0]  i_data_out,
    input  logic [pidl_pkg::IDX_OUT_W-1:0]      i_index_out,
    input  logic [pidl_pkg::STAT_W-1:0]         i_status,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pidl_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [IDX_OUT_W-1:0]     index;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } t_list_result;

    // Shadow copy of the list and the results still owed by the block
    logic signed [DATA_W-1:0] stored_values [CAPACITY];
    int                       stored_len = 0;
    t_list_result             expected_results [$];
    int                       mismatches = 0;
    int                       checked = 0;

    task automatic push_result(input logic signed [DATA_W-1:0] data, input int index,
                               input logic [STAT_W-1:0] status, input logic last);
        t_list_result r;
        r.data   = data;
        r.index  = index[IDX_OUT_W-1:0];
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // Apply one request to the shadow list and queue what it should produce
    task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
        int p;
        int i;
        p = int'(pos);
        case (kind)
            REQ_INS: begin
                if (p > stored_len) begin
                    push_result('0, 0, STAT_BADPOS, 1'b1);
                end else if (stored_len >= CAPACITY) begin
                    push_result('0, 0, STAT_FULL, 1'b1);
                end else begin
                    // open a hole at p
                    for (i = stored_len; i > p; i--)
                        stored_values[i] = stored_values[i-1];
                    stored_values[p] = val;
                    stored_len++;
                    push_result('0, 0, STAT_OK, 1'b1);
                end
            end
            REQ_DEL: begin
                if (p >= stored_len) begin
                    push_result('0, 0, STAT_BADPOS, 1'b1);
                end else begin
                    // close the gap left at p
                    for (i = p; i + 1 < stored_len; i++)
                        stored_values[i] = stored_values[i+1];
                    stored_len--;
                    push_result('0, 0, STAT_OK, 1'b1);
                end
            end
            REQ_READ: begin
                if (stored_len == 0) begin
                    push_result('0, 0, STAT_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < stored_len; i++)
                        push_result(stored_values[i], i, STAT_OK, i == stored_len - 1);
                end
            end
            default: begin
                // unused request code is rejected like a bad position
                push_result('0, 0, STAT_BADPOS, 1'b1);
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] list mismatch: %s", $time, msg);
    endtask

    // Request transfers are applied before the result transfer of the same edge,
    // so a result is always matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            stored_len = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_request(i_req_type, i_position, i_value);
            if (i_out_valid && i_out_ready) begin
                got.data   = i_data_out;
                got.index  = i_index_out;
                got.status = i_status;
                got.last   = i_last;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result data %0d index %0d status %0d last %0d",
                        got.data, got.index, got.status, got.last));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"expected data %0d index %0d status %0d ",
                            "last %0d, got data %0d index %0d status %0d last %0d"},
                            want.data, want.index, want.status, want.last,
                            got.data, got.index, got.status, got.last));
                    else
                        checked++;
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

[sim/positional_insert_delete_list_tb.sv]
module positional_insert_delete_list_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pidl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 50;

    typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY} t_stall_mode;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic [REQ_W-1:0]         req_type = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] data_out;
    logic [IDX_OUT_W-1:0]     index_out;
    logic [STAT_W-1:0]        status;
    logic                     last;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping
    int list_len = 0;
    int burst_left = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int full_hits = 0;
    int rejected = 0;
    int cycle_count = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_window = 0;

    positional_insert_delete_list dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_position  (position),
        .i_value     (value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_data_out  (data_out),
        .o_index_out (index_out),
        .o_status    (status),
        .o_last      (last)
    );

    list_result_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_position   (position),
        .i_value      (value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_data_out   (data_out),
        .i_index_out  (index_out),
        .i_status     (status),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Receiver backpressure: windows of free flow, coin flips and heavy stalls
    always @(posedge clk) begin
        if (stall_window == 0) begin
            stall_window <= $urandom_range(10, 60);
            stall_mode   <= t_stall_mode'($urandom_range(0, 2));
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            STALL_NONE: out_ready <= 1'b1;
            STALL_HALF: out_ready <= $urandom_range(0, 1);
            default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("positional_insert_delete_list_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One request transfer; bursts of back-to-back items with random gaps between
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= kind;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        kind_count[kind]++;
        case (kind)
            REQ_INS: begin
                if (pos > list_len)
                    rejected++;
                else if (list_len == CAPACITY)
                    full_hits++;
                else
                    list_len++;
            end
            REQ_DEL: begin
                if (pos >= list_len)
                    rejected++;
                else
                    list_len--;
            end
            REQ_READ: ;
            default: rejected++;
        endcase
    endtask

    // Mostly legal requests by weight; the remainder is arbitrary noise
    task automatic send_random_request(input int ins_pct, input int del_pct,
                                       input int read_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            send_request(REQ_INS, POS_W'($urandom_range(0, list_len)), pick_value());
        else if (roll < ins_pct + del_pct && list_len > 0)
            send_request(REQ_DEL, POS_W'($urandom_range(0, list_len - 1)), pick_value());
        else if (roll < ins_pct + del_pct + read_pct)
            send_request(REQ_READ, POS_W'($urandom), pick_value());
        else
            send_request(REQ_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
                         pick_value());
    endtask

    // Hold the sender off until every owed result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, bad positions, extremes, front/middle/end edits
        send_request(REQ_READ, 7'd0, 32'h0);
        send_request(REQ_DEL, 7'd0, 32'h0);
        send_request(REQ_INS, 7'd1, 32'h1234_5678);
        send_request(REQ_INS, 7'd127, 32'hffff_ffff);
        send_request(REQ_UNUSED, 7'd0, 32'h0);
        send_request(REQ_UNUSED, 7'd127, 32'hffff_ffff);
        send_request(REQ_INS, 7'd0, 32'h7fff_ffff);
        send_request(REQ_INS, 7'd0, 32'h8000_0000);
        send_request(REQ_INS, 7'd2, 32'hffff_ffff);
        send_request(REQ_INS, 7'd1, 32'h0);
        send_request(REQ_INS, 7'd5, 32'h5555_5555);
        send_request(REQ_READ, 7'd127, 32'haaaa_aaaa);
        send_request(REQ_DEL, 7'd4, 32'h0);
        send_request(REQ_DEL, 7'd1, 32'h0);
        send_request(REQ_DEL, 7'd2, 32'h0);
        send_request(REQ_DEL, 7'd0, 32'h0);
        send_request(REQ_READ, 7'd0, 32'h0);
        send_request(REQ_DEL, 7'd127, 32'h0);
        send_request(REQ_DEL, 7'd0, 32'h0);
        send_request(REQ_READ, 7'd0, 32'h0);
        wait_drained();

        // Mixed traffic on a small list
        repeat (25) send_random_request(45, 25, 10);
        wait_drained();

        // Fill to capacity, then poke the full store
        while (list_len < CAPACITY) send_random_request(85, 5, 5);
        send_request(REQ_INS, 7'd0, pick_value());
        send_request(REQ_INS, POS_W'(CAPACITY), pick_value());
        send_request(REQ_INS, POS_W'(CAPACITY + 1), pick_value());
        send_request(REQ_INS, 7'd127, pick_value());
        send_request(REQ_READ, 7'd0, 32'h0);
        send_request(REQ_DEL, POS_W'(CAPACITY - 1), 32'h0);
        send_request(REQ_INS, POS_W'(CAPACITY - 1), pick_value());
        send_request(REQ_INS, POS_W'($urandom_range(0, CAPACITY)), pick_value());
        send_request(REQ_READ, 7'd0, 32'h0);
        wait_drained();

        // Drain back to empty with read-outs along the way
        while (list_len > 0) send_random_request(5, 75, 12);
        send_request(REQ_READ, 7'd0, 32'h0);

        // Mixed traffic again
        repeat (15) send_random_request(40, 35, 10);

        // Finish: wait for every owed result, then watch for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d deletes, %0d read-outs and %0d unused codes",
                 kind_count[REQ_INS], kind_count[REQ_DEL], kind_count[REQ_READ],
                 kind_count[REQ_UNUSED]);
        $display("%0d results matched; %0d inserts hit a full store, %0d requests rejected",
                 checked, full_hits, rejected);
        if (fail_count == 0 && pending == 0) begin
            $display("positional_insert_delete_list_tb OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending);
            $display("positional_insert_delete_list_tb NOT OK");
        end
        $finish;
    end

endmodule
